@@ rtl/b64le_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types, constants and the base64 alphabet lookup for the line encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

  localparam logic [7:0] LINE_FEED = 8'd10;
  localparam logic [7:0] PAD_CHAR  = 8'd61;
  localparam logic [5:0] COUNT_MAX = 6'd63;
  localparam logic [5:0] GPL_RESET = 6'd19;

  // One raw byte and its end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } b64le_in_t;

  // One output character and its last-of-group flag.
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } b64le_out_t;

  // A closed group handed from the front to the back. Missing bytes are zero.
  typedef struct packed {
    logic       lf;
    logic [1:0] nbytes;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } b64le_group_t;

  // Standard base64 alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd97 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'd48 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

endpackage

@@ rtl/b64le_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_fifo
// Short queue of closed groups between the front and the back.
// ----------------------------------------------------------------------------
module b64le_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  b64le_pkg::b64le_group_t wr_data,
  input  logic                   rd_en,
  output b64le_pkg::b64le_group_t rd_data,
  output logic                   full,
  output logic                   empty
);
  import b64le_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  b64le_group_t  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk) disable iff (rst) !(wr_en && full))
    else $error("group queue written while full");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) !(rd_en && empty))
    else $error("group queue read while empty");
  a_count_range : assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("group queue count out of range");
`endif

endmodule

@@ rtl/b64le_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_front
// Collects bytes into groups, tracks the line count and queues closed groups.
// ----------------------------------------------------------------------------
module b64le_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  b64le_pkg::b64le_in_t    in_item,
  input  logic [5:0]              groups_per_line,
  output logic                    grp_push,
  output b64le_pkg::b64le_group_t grp
);
  import b64le_pkg::*;

  logic [7:0] held0;
  logic [7:0] held1;
  logic [1:0] phase;
  logic [5:0] line_cnt;
  logic [5:0] line_cnt_next;
  logic       closes;
  logic       lf;

  assign closes   = (phase == 2'd2) || in_item.is_last;
  assign grp_push = accept && closes;
  assign lf       = (groups_per_line != 6'd0) && (line_cnt >= groups_per_line);

  always_comb begin
    grp.lf     = lf;
    grp.nbytes = phase + 2'd1;
    grp.b0     = (phase == 2'd0) ? in_item.data_byte : held0;
    grp.b1     = (phase == 2'd1) ? in_item.data_byte : ((phase == 2'd2) ? held1 : 8'd0);
    grp.b2     = (phase == 2'd2) ? in_item.data_byte : 8'd0;
  end

  always_comb begin
    if (in_item.is_last) begin
      line_cnt_next = 6'd0;
    end else if (lf) begin
      line_cnt_next = 6'd1;
    end else if (line_cnt < COUNT_MAX) begin
      line_cnt_next = line_cnt + 6'd1;
    end else begin
      line_cnt_next = line_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !closes) begin
      if (phase == 2'd0) begin
        held0 <= in_item.data_byte;
      end else begin
        held1 <= in_item.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 2'd0;
      line_cnt <= 6'd0;
    end else if (accept) begin
      if (closes) begin
        phase    <= 2'd0;
        line_cnt <= line_cnt_next;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

endmodule

@@ rtl/b64le_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_back
// Walks each queued group into out_item, one character per unstalled cycle.
// ----------------------------------------------------------------------------
module b64le_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    grp_empty,
  input  b64le_pkg::b64le_group_t grp,
  output logic                    grp_pop,
  input  logic                    pop,
  output logic                    empty,
  output b64le_pkg::b64le_out_t   out_item
);
  import b64le_pkg::*;

  localparam logic [2:0] STEP_LF = 3'd0;
  localparam logic [2:0] STEP_C0 = 3'd1;
  localparam logic [2:0] STEP_C1 = 3'd2;
  localparam logic [2:0] STEP_C2 = 3'd3;
  localparam logic [2:0] STEP_C3 = 3'd4;

  logic [2:0] step;
  logic [2:0] cur_step;
  logic       out_valid;
  logic       load;
  logic [7:0] ch;

  // A group without a line feed starts straight at its first character.
  assign cur_step = (step == STEP_LF && !grp.lf) ? STEP_C0 : step;
  assign load     = !grp_empty && (!out_valid || pop);
  assign grp_pop  = load && (cur_step == STEP_C3);
  assign empty    = !out_valid;

  always_comb begin
    case (cur_step)
      STEP_LF: ch = LINE_FEED;
      STEP_C0: ch = b64_char(grp.b0[7:2]);
      STEP_C1: ch = b64_char({grp.b0[1:0], grp.b1[7:4]});
      STEP_C2: ch = (grp.nbytes >= 2'd2) ? b64_char({grp.b1[3:0], grp.b2[7:6]}) : PAD_CHAR;
      STEP_C3: ch = (grp.nbytes == 2'd3) ? b64_char(grp.b2[5:0]) : PAD_CHAR;
      default: ch = PAD_CHAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.out_char <= ch;
      out_item.out_last <= (cur_step == STEP_C3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_LF;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= (cur_step == STEP_C3) ? STEP_LF : cur_step + 3'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/base64_line_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_line_encoder
// Streaming base64 encoder with optional line feeds every N groups.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   -------  --------------------  ---------------------------------
//   input    push / full           in_item  {data_byte, is_last}
//   result   empty / pop           out_item {out_char, out_last}
//   config   cfg_valid/cfg_ready   cfg_data = groups_per_line
//
// A byte is taken every cycle while the group queue has room; one character
// leaves per cycle while pop is held and a group is waiting, through the
// single output character register.
// Reset is synchronous: it clears the byte phase, the line count and the
// queue, and restores groups_per_line to 19 (76 characters per line).
// A stalled result side fills the queue, which raises full; while full is
// high no byte is taken, whether or not it closes a group, until the back
// end frees a slot.
// ----------------------------------------------------------------------------
module base64_line_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  b64le_pkg::b64le_in_t  in_item,
  output logic                  empty,
  input  logic                  pop,
  output b64le_pkg::b64le_out_t out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [5:0]            cfg_data
);
  import b64le_pkg::*;

  logic [5:0]   groups_per_line;
  logic         accept;
  logic         grp_push;
  logic         grp_pop;
  logic         grp_full;
  logic         grp_empty;
  b64le_group_t grp_wr;
  b64le_group_t grp_rd;

  // Always writable; the user must make writes only while the block idles.
  assign cfg_ready = 1'b1;

  // Full follows the queue so a byte that closes a group always has a slot.
  assign full   = grp_full;
  assign accept = push && !grp_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_line <= GPL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      groups_per_line <= cfg_data;
    end
  end

  // Front end: grouping and line-feed decision.
  b64le_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .in_item         (in_item),
    .groups_per_line (groups_per_line),
    .grp_push        (grp_push),
    .grp             (grp_wr)
  );

  // Decoupling queue of closed groups.
  b64le_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grp_push),
    .wr_data (grp_wr),
    .rd_en   (grp_pop),
    .rd_data (grp_rd),
    .full    (grp_full),
    .empty   (grp_empty)
  );

  // Back end: character sequencing and output register.
  b64le_back u_back (
    .clk       (clk),
    .rst       (rst),
    .grp_empty (grp_empty),
    .grp       (grp_rd),
    .grp_pop   (grp_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule

@@ tb/b64le_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_checker
// Watches the byte, character and configuration channels of the line encoder.
// It keeps its own copy of the encoder state, works out the characters that
// each accepted byte must produce, and compares every popped character with
// the oldest one still expected.
// ----------------------------------------------------------------------------
module b64le_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  b64le_pkg::b64le_in_t  in_item,
  input  logic                  empty,
  input  logic                  pop,
  input  b64le_pkg::b64le_out_t out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [5:0]            cfg_data,
  output int                    mismatch_count,
  output int                    chars_outstanding
);
  import b64le_pkg::*;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [5:0] line_limit;
  logic [7:0] held_data [2];
  logic [1:0] held_count;
  logic [5:0] groups_on_line;
  b64le_out_t expected_chars [$];
  int         mismatches = 0;
  int         outstanding = 0;

  assign mismatch_count    = mismatches;
  assign chars_outstanding = outstanding;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    int pos;
    pos = (63 - int'(v)) * 8;
    return ALPHABET[pos +: 8];
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Takes one accepted byte and queues the characters it closes, if any.
  task automatic encode_byte(input b64le_in_t it);
    logic [7:0] b0, b1, b2;
    logic [7:0] chars [5];
    int         n;
    b64le_out_t c;
    n = 0;
    if (held_count < 2'd2 && !it.is_last) begin
      held_data[held_count[0]] = it.data_byte;
      held_count++;
    end else begin
      b0 = (held_count == 2'd0) ? it.data_byte : held_data[0];
      b1 = (held_count == 2'd1) ? it.data_byte :
           (held_count == 2'd2) ? held_data[1] : 8'h00;
      b2 = (held_count == 2'd2) ? it.data_byte : 8'h00;
      if (line_limit != 6'd0 && groups_on_line >= line_limit) begin
        chars[n] = LINE_FEED;
        n++;
        groups_on_line = 6'd0;
      end
      chars[n]     = sextet_char(b0[7:2]);
      chars[n + 1] = sextet_char({b0[1:0], b1[7:4]});
      chars[n + 2] = (held_count >= 2'd1) ? sextet_char({b1[3:0], b2[7:6]}) : PAD_CHAR;
      chars[n + 3] = (held_count == 2'd2) ? sextet_char(b2[5:0]) : PAD_CHAR;
      n += 4;
      if (groups_on_line != COUNT_MAX) groups_on_line++;
      held_count = 2'd0;
      if (it.is_last) groups_on_line = 6'd0;
      for (int k = 0; k < n; k++) begin
        c.out_char = chars[k];
        c.out_last = (k == n - 1);
        expected_chars.push_back(c);
      end
    end
  endtask

  always @(posedge clk) begin : watch_channels
    b64le_out_t want;
    if (rst) begin
      line_limit     = GPL_RESET;
      held_data[0]   = 8'h00;
      held_data[1]   = 8'h00;
      held_count     = 2'd0;
      groups_on_line = 6'd0;
      expected_chars.delete();
    end else begin
      // Characters are checked before this edge's byte is added, since a
      // byte can never produce a character in the cycle it is taken.
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h", out_item.out_char));
        end else begin
          want = expected_chars.pop_front();
          if (out_item.out_char !== want.out_char)
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                      out_item.out_char, want.out_char));
          if (out_item.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %b, expected %b",
                                      out_item.out_last, want.out_last));
        end
      end
      // A byte taken at the same edge as a write still sees the old setting.
      if (push && !full) encode_byte(in_item);
      if (cfg_valid && cfg_ready) line_limit = cfg_data;
    end
    outstanding = expected_chars.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the base64 line encoder.
// Bytes go in as whole messages with random content and random gaps, the
// result side pops with random stalls, and the wrap setting is changed
// between phases while the encoder is drained. All checking is done by the
// checker instance, which reports its mismatch count back here.
// ----------------------------------------------------------------------------
module tb;
  import b64le_pkg::*;

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  b64le_in_t  in_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  b64le_out_t out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data = 6'd0;

  int         mismatch_count;
  int         chars_outstanding;

  // When set, both sides run flat out: no gaps on push and pop held high.
  logic       steady = 1'b0;
  // Mirror of the wrap setting last written, used to pick lower values.
  int         line_groups = GPL_RESET;

  base64_line_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  b64le_checker i_checker (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .in_item           (in_item),
    .empty             (empty),
    .pop               (pop),
    .out_item          (out_item),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .chars_outstanding (chars_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Message lengths: mostly short so that every padding case comes up
  // often, sometimes long enough to wrap lines at settings up to 13 groups.
  function automatic int next_msg_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 9);
    return $urandom_range(10, 40);
  endfunction

  // Result side. Pop is driven at the falling edge in bursts separated by
  // random stalls, or held high for the whole of a steady phase.
  initial begin : drive_pop
    int run;
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (steady) begin
        pop <= 1'b1;
        @(negedge clk);
      end else begin
        run = $urandom_range(1, 12);
        pop <= 1'b1;
        repeat (run) @(negedge clk);
        gap = next_gap();
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Offers one byte and returns at the falling edge after it was taken.
  // Push stays high into the next item unless a gap is drawn, so back to
  // back items never see push dropped and raised in the same time step.
  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = steady ? 0 : next_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= '{data_byte: value, is_last: last};
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Sends count random bytes; the final one is flagged as the end of the
  // message only when close is set, otherwise the message stays open.
  task automatic send_random_bytes(input int count, input logic close);
    for (int i = 0; i < count; i++)
      send_byte(8'($urandom_range(0, 255)), close && (i == count - 1));
  endtask

  // Stops the byte stream, waits for every expected character to leave,
  // then lets the back end settle. Bytes held inside an open group produce
  // nothing yet, so the extra cycles cover any work still in flight.
  task automatic drain();
    push <= 1'b0;
    while (chars_outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // The wrap setting is only changed with the encoder drained.
  task automatic set_groups_per_line(input int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= 6'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    line_groups = value;
  endtask

  initial begin : limit_run
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int phase_setting [8];
    int sent;
    int len;
    int split;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, default of 19 groups per line. Single bytes at both
    // extremes give the two-pad group, two bytes the one-pad group, three
    // bytes a full group, and four bytes a full group plus a short one.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // One group per line: the first group of the message gets no line
    // feed, the next two each get one. The message after it starts on a
    // fresh count, so its only group has no line feed in front.
    set_groups_per_line(1);
    send_random_bytes(9, 1'b1);
    send_random_bytes(3, 1'b1);

    // Wrapping off with one long open message: 65 groups push the line
    // count to its ceiling, where it must stick. Raising the setting to 63
    // while the message is still open then calls for a line feed before
    // the very next group, which a wrapped count would not.
    set_groups_per_line(0);
    send_random_bytes(195, 1'b0);
    set_groups_per_line(63);
    send_random_bytes(3, 1'b1);

    // Random phases. Settings include both extremes; every third phase
    // runs without any idling on either side. Now and then a message is
    // cut in two, the encoder drained, and the setting lowered to at most its
    // current value before the message is finished.
    phase_setting = '{63, 1, 2, 0, 3, 7, 19, $urandom_range(0, 63)};
    for (int p = 0; p < 8; p++) begin
      set_groups_per_line(phase_setting[p]);
      steady = (p % 3 == 2);
      sent = 0;
      while (sent < 2) begin
        len = next_msg_length();
        if (len > 3 && $urandom_range(0, 5) == 0) begin
          split = $urandom_range(1, len - 1);
          send_random_bytes(split, 1'b0);
          set_groups_per_line($urandom_range(0, line_groups));
          send_random_bytes(len - split, 1'b1);
        end else begin
          send_random_bytes(len, 1'b1);
        end
        sent += len;
      end
      steady = 1'b0;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
